### src/multichannel_fir_lowpass_16tap_unit_assert.svh
// Assertion macros used by the multichannel FIR filter back end.
// Expects clk and rst in the scope of every use; no other dependencies.
`ifndef MULTICHANNEL_FIR_LOWPASS_16TAP_UNIT_ASSERT_SVH
`define MULTICHANNEL_FIR_LOWPASS_16TAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MFIR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mfir assertion failed");
`define MFIR_ASSERT_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("mfir assertion failed");
`else
`define MFIR_ASSERT(lbl, prop)
`define MFIR_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

### src/mfir_pkg.sv
// Types, codes and the fixed Q1.15 tap table of the multichannel FIR filter.
// No dependencies; used by every module of the block.
package mfir_pkg;

  localparam int TAPS        = 16;
  localparam int SAMPLE_W    = 16;
  localparam int SLOT_W      = 4;
  localparam int CHAN_W      = 2;
  localparam int CMD_W       = 2;
  localparam int PROD_W      = 30;
  localparam int ACC_W       = 32;
  localparam int GROUP_SIZE  = 4;
  localparam int GROUPS      = TAPS / GROUP_SIZE;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int FRAC_W      = 15;
  localparam int AVG_SHIFT   = 4;

  // Command codes on the input tuser
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_AVG  = 2'd2;

  // Q1.15 low-pass taps, symmetric
  localparam logic signed [SAMPLE_W-1:0] COEF [TAPS] = '{
    16'sd331, -16'sd13, -16'sd881, -16'sd1461, -16'sd501, 16'sd2536, 16'sd6622, 16'sd9565,
    16'sd9565, 16'sd6622, 16'sd2536, -16'sd501, -16'sd1461, -16'sd881, -16'sd13, 16'sd331
  };

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [TAPS-1:0] line_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_FIR,
    KIND_AVG
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [CHAN_W-1:0]   channel;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/mfir_front.sv
// Front end: decodes incoming requests, drops unused commands and channels,
// and pushes the rest into the queue. Depends on mfir_pkg.
module mfir_front #(
  parameter int CHANNELS = 4
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mfir_pkg::CMD_W-1:0]    command,
  input  logic [mfir_pkg::CHAN_W-1:0]   channel,
  input  logic [mfir_pkg::SLOT_W-1:0]   slot,
  input  logic [mfir_pkg::SAMPLE_W-1:0] sample,
  input  mfir_pkg::q_status_t           q_status,
  output logic                          push,
  output mfir_pkg::item_t               push_item
);

  logic cmd_ok;
  logic chan_ok;

  // Accept whenever the queue has room
  assign in_ready = !q_status.full;

  // Classify the command and build the queue entry
  always_comb begin
    cmd_ok            = 1'b1;
    push_item.kind    = mfir_pkg::KIND_LOAD;
    push_item.channel = channel;
    push_item.slot    = slot;
    push_item.sample  = sample;
    case (command)
      mfir_pkg::CMD_LOAD: push_item.kind = mfir_pkg::KIND_LOAD;
      mfir_pkg::CMD_FIR:  push_item.kind = mfir_pkg::KIND_FIR;
      mfir_pkg::CMD_AVG:  push_item.kind = mfir_pkg::KIND_AVG;
      default:            cmd_ok         = 1'b0;
    endcase
  end

  assign chan_ok = (32'(channel) < CHANNELS);

  // Drop requests that change nothing
  assign push = in_valid && in_ready && cmd_ok && chan_ok;

endmodule

### src/mfir_queue.sv
// Short FIFO of decoded requests between front and back end.
// Depends on mfir_pkg.
module mfir_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mfir_pkg::item_t     push_item,
  input  logic                pop,
  output mfir_pkg::item_t     head,
  output mfir_pkg::q_status_t status
);

  mfir_pkg::item_t            mem [mfir_pkg::QUEUE_DEPTH];
  logic [mfir_pkg::QPTR_W-1:0] wr_ptr;
  logic [mfir_pkg::QPTR_W-1:0] rd_ptr;
  logic [mfir_pkg::QPTR_W:0]   count;
  logic                        do_push;
  logic                        do_pop;

  assign status.full  = (count == (mfir_pkg::QPTR_W+1)'(mfir_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/mfir_back.sv
// Back end: per-channel delay lines, sixteen multipliers, a registered
// adder tree and the truncate/saturate or average output register. Depends on mfir_pkg.
`include "multichannel_fir_lowpass_16tap_unit_assert.svh"
module mfir_back #(
  parameter int CHANNELS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mfir_pkg::item_t               q_item,
  input  mfir_pkg::q_status_t           q_status,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mfir_pkg::CHAN_W-1:0]   out_channel,
  output logic [mfir_pkg::SAMPLE_W-1:0] filtered,
  output logic                          saturated
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  mfir_pkg::line_t lines [CHANNELS];

  logic                                 advance;
  logic                                 gives_result;
  logic [CH_W-1:0]                      ch_idx;
  mfir_pkg::line_t                      row_cur;
  mfir_pkg::line_t                      row_in;
  mfir_pkg::line_t                      row_shift;
  mfir_pkg::line_t                      row_load;
  logic signed [mfir_pkg::ACC_W-1:0]    full_prod [mfir_pkg::TAPS];

  // Stage 1: products
  logic                                 v1;
  logic                                 s1_fir;
  logic [mfir_pkg::CHAN_W-1:0]          s1_ch;
  logic signed [mfir_pkg::PROD_W-1:0]   prod1 [mfir_pkg::TAPS];
  // Stage 2: partial sums
  logic                                 v2;
  logic                                 s2_fir;
  logic [mfir_pkg::CHAN_W-1:0]          s2_ch;
  logic signed [mfir_pkg::ACC_W-1:0]    part_next [mfir_pkg::GROUPS];
  logic signed [mfir_pkg::ACC_W-1:0]    part2 [mfir_pkg::GROUPS];
  // Stage 3: total
  logic                                 v3;
  logic                                 s3_fir;
  logic [mfir_pkg::CHAN_W-1:0]          s3_ch;
  logic signed [mfir_pkg::ACC_W-1:0]    total_next;
  logic signed [mfir_pkg::ACC_W-1:0]    total3;
  // Output stage
  logic signed [mfir_pkg::ACC_W-1:0]    biased;
  logic signed [mfir_pkg::ACC_W-1:0]    quot;
  logic signed [mfir_pkg::ACC_W-1:0]    avg;
  logic [mfir_pkg::SAMPLE_W-1:0]        filtered_next;
  logic                                 saturated_next;

  // Move the whole pipe unless the output register is held
  assign advance      = !out_valid || out_ready;
  assign pop          = advance && !q_status.empty;
  assign gives_result = (q_item.kind == mfir_pkg::KIND_FIR) ||
                        (q_item.kind == mfir_pkg::KIND_AVG);
  assign ch_idx       = CH_W'(q_item.channel);
  assign row_cur      = lines[ch_idx];

  // Build the updated line for the head request
  always_comb begin
    row_in = row_cur;
    if (q_item.kind == mfir_pkg::KIND_FIR) begin
      row_in[mfir_pkg::TAPS-1] = q_item.sample;
    end
    for (int k = 0; k < mfir_pkg::TAPS - 1; k++) begin
      row_shift[k] = row_in[k+1];
    end
    row_shift[mfir_pkg::TAPS-1] = row_in[mfir_pkg::TAPS-1];
    row_load = row_cur;
    row_load[q_item.slot] = q_item.sample;
  end

  // Multiply by the taps, or pass samples through for the average
  always_comb begin
    for (int j = 0; j < mfir_pkg::TAPS; j++) begin
      if (q_item.kind == mfir_pkg::KIND_FIR) begin
        full_prod[j] = mfir_pkg::ACC_W'(mfir_pkg::COEF[j]) *
                       mfir_pkg::ACC_W'($signed(row_in[mfir_pkg::TAPS-1-j]));
      end else begin
        full_prod[j] = mfir_pkg::ACC_W'($signed(row_in[j]));
      end
    end
  end

  // Update the delay lines and the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lines[c] <= '0;
      end
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (pop) begin
        case (q_item.kind)
          mfir_pkg::KIND_LOAD: lines[ch_idx] <= row_load;
          mfir_pkg::KIND_FIR:  lines[ch_idx] <= row_shift;
          mfir_pkg::KIND_AVG:  lines[ch_idx] <= row_shift;
          default:             lines[ch_idx] <= row_cur;
        endcase
      end
      v1        <= pop && gives_result;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Sum groups of four products
  always_comb begin
    for (int g = 0; g < mfir_pkg::GROUPS; g++) begin
      part_next[g] = '0;
      for (int i = 0; i < mfir_pkg::GROUP_SIZE; i++) begin
        part_next[g] = part_next[g] +
                       mfir_pkg::ACC_W'(prod1[g*mfir_pkg::GROUP_SIZE+i]);
      end
    end
  end

  // Sum the partial sums
  always_comb begin
    total_next = '0;
    for (int g = 0; g < mfir_pkg::GROUPS; g++) begin
      total_next = total_next + part2[g];
    end
  end

  // Truncate toward zero and clamp, or floor-divide the average
  always_comb begin
    biased = total3 + (total3[mfir_pkg::ACC_W-1] ?
                       mfir_pkg::ACC_W'((1 << mfir_pkg::FRAC_W) - 1) : '0);
    quot   = biased >>> mfir_pkg::FRAC_W;
    avg    = total3 >>> mfir_pkg::AVG_SHIFT;
    saturated_next = 1'b0;
    if (s3_fir) begin
      if (quot > mfir_pkg::ACC_W'(32767)) begin
        filtered_next  = 16'h7fff;
        saturated_next = 1'b1;
      end else if (quot < -mfir_pkg::ACC_W'(32768)) begin
        filtered_next  = 16'h8000;
        saturated_next = 1'b1;
      end else begin
        filtered_next  = quot[mfir_pkg::SAMPLE_W-1:0];
      end
    end else begin
      filtered_next = avg[mfir_pkg::SAMPLE_W-1:0];
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_fir <= (q_item.kind == mfir_pkg::KIND_FIR);
      s1_ch  <= q_item.channel;
      for (int j = 0; j < mfir_pkg::TAPS; j++) begin
        prod1[j] <= full_prod[j][mfir_pkg::PROD_W-1:0];
      end
      s2_fir <= s1_fir;
      s2_ch  <= s1_ch;
      part2  <= part_next;
      s3_fir <= s2_fir;
      s3_ch  <= s2_ch;
      total3 <= total_next;
      out_channel <= s3_ch;
      filtered    <= filtered_next;
      saturated   <= saturated_next;
    end
  end

  `MFIR_ASSERT_NEXT(a_hold_on_stall, !advance, $stable(v1) && $stable(v3))
  `MFIR_ASSERT_NEXT(a_issue_result, pop && gives_result, v1)
  `MFIR_ASSERT_NEXT(a_avg_never_sat, advance && v3 && !s3_fir, !saturated)

endmodule

### src/multichannel_fir_lowpass_16tap_unit.sv
// Top level of the multichannel 16-tap FIR low-pass filter with boxcar mode.
// Depends on mfir_pkg, mfir_front, mfir_queue and mfir_back.
//
// Channel   Dir  tdata (low bit up)                       tuser
// s_axis    in   channel[1:0] slot[5:2] sample[21:6]      command[1:0]
// m_axis    out  out_channel[1:0] filtered[17:2]          saturated[0]
//
// One request per cycle is taken while the queue has room; a filter or
// average result is registered in the queue, products, partial sums, total
// and output register in turn. Loads update the delay line and give no result.
// Reset clears the queue, the pipeline valid flags and all delay lines.
// A held output freezes the back pipeline; the four-entry queue keeps
// s_axis_tready high until it fills.
module multichannel_fir_lowpass_16tap_unit #(
  parameter int CHANNELS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // channel, slot, sample, zero pad
  input  logic [mfir_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // command
  input  logic [mfir_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_channel, filtered, zero pad
  output logic [mfir_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // saturated
  output logic                               m_axis_tuser
);

  mfir_pkg::q_status_t            q_status;
  mfir_pkg::item_t                push_item;
  mfir_pkg::item_t                head;
  logic                           push;
  logic                           pop;
  logic [mfir_pkg::CHAN_W-1:0]    out_channel;
  logic [mfir_pkg::SAMPLE_W-1:0]  filtered;

  mfir_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .command   (s_axis_tuser),
    .channel   (s_axis_tdata[1:0]),
    .slot      (s_axis_tdata[5:2]),
    .sample    (s_axis_tdata[21:6]),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  mfir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  mfir_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_channel (out_channel),
    .filtered    (filtered),
    .saturated   (m_axis_tuser)
  );

  // Pack the result
  assign m_axis_tdata = {6'b0, filtered, out_channel};

endmodule
